@@ sv/ihex_pkg.sv @@
package ihex_pkg;

  localparam int COUNT_BITS = 16;

  localparam logic [7:0] CHAR_MARK = 8'h3A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  localparam logic [7:0] EOF_TYPE_RESET = 8'h01;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_STREAM = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MARK   = 3'd1,
    ST_LENGTH = 3'd2,
    ST_CHKSUM = 3'd3,
    ST_NOEOF  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_address;
    logic [7:0]  record_type;
    status_t     status;
    logic [15:0] record_number;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end
    return v;
  endfunction

  function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] n);
    logic [COUNT_BITS+15:0] w;
    w = (COUNT_BITS+16)'(n);
    if (w > (COUNT_BITS+16)'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

@@ sv/intel_hex_record_parser.sv @@
// Channel   Dir  Signals                          Contents
// s_axis    in   s_tvalid s_tready s_tdata[7:0]   char_code; s_tlast = end_of_input
// m_axis    out  m_tvalid m_tready m_tdata[55:0]  result fields; m_tuser = kind
// cfg       in   cfg_we cfg_data[7:0]             eof_record_type
//
// One character is taken per cycle while the output is not stalled; each result
// passes the input register, then the result register, before it is offered.
// Reset clears all parser state and sets eof_record_type to 1.
// A stalled output holds its result; the input keeps flowing while the result
// register is free or being emptied in the same cycle.
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  // byte_value, byte_address, record_type, status, record_number, zero fill
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import ihex_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.char_code = s_tdata;
  assign in_item.end_of_input = s_tlast;
  assign advance = item_valid && out_free;

  ihex_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (advance)
  );

  ihex_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ihex_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {5'b0, out_res.record_number, out_res.status, out_res.record_type,
                    out_res.byte_address, out_res.byte_value};

endmodule

@@ sv/ihex_in_stage.sv @@
module ihex_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ihex_pkg::item_t in_item,
  output logic          item_valid,
  output ihex_pkg::item_t item,
  input  logic          take
);
  import ihex_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ sv/ihex_core.sv @@
module ihex_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              advance,
  input  ihex_pkg::item_t   item,
  output logic              res_valid,
  output ihex_pkg::result_t res
);
  import ihex_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA,
    PH_CHK, PH_EOL, PH_EOL_LF, PH_SKIP, PH_ERR, PH_DONE
  } phase_t;

  logic [7:0]            eof_type;
  phase_t                phase, phase_next;
  logic                  second, second_next;
  logic [3:0]            high_nibble, high_nibble_next;
  logic [7:0]            record_length, record_length_next;
  logic [15:0]           record_address, record_address_next;
  logic [7:0]            current_type, current_type_next;
  logic [7:0]            bytes_done, bytes_done_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [COUNT_BITS-1:0] records_seen, records_seen_next;
  logic [7:0]            last_type, last_type_next;
  logic                  any_record, any_record_next;
  status_t               held_error, held_error_next;

  logic       ended;
  logic       do_fail;
  status_t    fail_code;
  logic       complete;
  logic [7:0] byte_val;
  logic [7:0] c;
  status_t    final_code;

  always_comb begin
    c = item.char_code;
    ended = item.end_of_input || (c == CHAR_NUL);
    phase_next = phase;
    second_next = second;
    high_nibble_next = high_nibble;
    record_length_next = record_length;
    record_address_next = record_address;
    current_type_next = current_type;
    bytes_done_next = bytes_done;
    running_sum_next = running_sum;
    records_seen_next = records_seen;
    last_type_next = last_type;
    any_record_next = any_record;
    held_error_next = held_error;
    res_valid = 1'b0;
    res = '0;
    do_fail = 1'b0;
    fail_code = ST_OK;
    complete = 1'b0;
    final_code = ST_OK;
    byte_val = {high_nibble, hex_value(c)};

    if (phase == PH_DONE) begin
      res_valid = 1'b0;
    end else if (ended) begin
      if (held_error != ST_OK) begin
        final_code = held_error;
      end else if (phase != PH_START && phase != PH_SKIP) begin
        final_code = ST_LENGTH;
      end else if (!any_record || last_type != eof_type) begin
        final_code = ST_NOEOF;
      end
      phase_next = PH_DONE;
      res_valid = 1'b1;
      res.kind = KIND_STREAM;
      res.record_type = last_type;
      res.status = final_code;
      res.record_number = sat16(records_seen);
    end else begin
      case (phase)
        PH_START, PH_SKIP: begin
          if (phase == PH_START || c == CHAR_MARK) begin
            if (records_seen != {COUNT_BITS{1'b1}}) begin
              records_seen_next = records_seen + COUNT_BITS'(1);
            end
            second_next = 1'b0;
            high_nibble_next = '0;
            record_length_next = '0;
            record_address_next = '0;
            current_type_next = '0;
            bytes_done_next = '0;
            running_sum_next = '0;
            phase_next = PH_LEN;
          end
          if (phase == PH_START && c != CHAR_MARK) begin
            do_fail = 1'b1;
            fail_code = ST_MARK;
          end
        end
        PH_ERR: begin
          res_valid = 1'b0;
        end
        PH_EOL: begin
          if (c == CHAR_LF) begin
            complete = 1'b1;
          end else if (c == CHAR_CR) begin
            phase_next = PH_EOL_LF;
          end else begin
            do_fail = 1'b1;
            fail_code = ST_LENGTH;
          end
        end
        PH_EOL_LF: begin
          if (c == CHAR_LF) begin
            complete = 1'b1;
          end else begin
            do_fail = 1'b1;
            fail_code = ST_LENGTH;
          end
        end
        default: begin
          if (phase == PH_DATA && (c == CHAR_LF || c == CHAR_CR)) begin
            do_fail = 1'b1;
            fail_code = ST_LENGTH;
          end else if (!second) begin
            high_nibble_next = hex_value(c);
            second_next = 1'b1;
          end else begin
            second_next = 1'b0;
            running_sum_next = running_sum + byte_val;
            case (phase)
              PH_LEN: begin
                record_length_next = byte_val;
                phase_next = PH_ADDR_HI;
              end
              PH_ADDR_HI: begin
                record_address_next = {byte_val, 8'h00};
                phase_next = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                record_address_next = {record_address[15:8], byte_val};
                phase_next = PH_TYPE;
              end
              PH_TYPE: begin
                current_type_next = byte_val;
                phase_next = (record_length == 8'd0) ? PH_CHK : PH_DATA;
              end
              PH_DATA: begin
                res_valid = 1'b1;
                res.kind = KIND_DATA;
                res.byte_value = byte_val;
                res.byte_address = record_address + 16'(bytes_done);
                res.record_type = current_type;
                res.status = ST_OK;
                res.record_number = sat16(records_seen);
                bytes_done_next = bytes_done + 8'd1;
                if (bytes_done + 8'd1 == record_length) begin
                  phase_next = PH_CHK;
                end
              end
              default: begin
                phase_next = PH_EOL;
              end
            endcase
          end
        end
      endcase

      if (complete) begin
        if (running_sum != 8'd0) begin
          do_fail = 1'b1;
          fail_code = ST_CHKSUM;
        end else begin
          last_type_next = current_type;
          any_record_next = 1'b1;
          phase_next = PH_SKIP;
          res_valid = 1'b1;
          res.kind = KIND_RECORD;
          res.byte_address = record_address;
          res.record_type = current_type;
          res.status = ST_OK;
          res.record_number = sat16(records_seen);
        end
      end

      if (do_fail) begin
        held_error_next = fail_code;
        phase_next = PH_ERR;
        res_valid = 1'b1;
        res = '0;
        res.kind = KIND_RECORD;
        res.byte_address = record_address_next;
        res.record_type = current_type_next;
        res.status = fail_code;
        res.record_number = sat16(records_seen_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eof_type <= EOF_TYPE_RESET;
      phase <= PH_START;
      second <= 1'b0;
      high_nibble <= '0;
      record_length <= '0;
      record_address <= '0;
      current_type <= '0;
      bytes_done <= '0;
      running_sum <= '0;
      records_seen <= '0;
      last_type <= '0;
      any_record <= 1'b0;
      held_error <= ST_OK;
    end else begin
      if (cfg_we) begin
        eof_type <= cfg_data;
      end
      if (advance) begin
        phase <= phase_next;
        second <= second_next;
        high_nibble <= high_nibble_next;
        record_length <= record_length_next;
        record_address <= record_address_next;
        current_type <= current_type_next;
        bytes_done <= bytes_done_next;
        running_sum <= running_sum_next;
        records_seen <= records_seen_next;
        last_type <= last_type_next;
        any_record <= any_record_next;
        held_error <= held_error_next;
      end
    end
  end

endmodule

@@ sv/ihex_out_stage.sv @@
module ihex_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ihex_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output ihex_pkg::result_t out_res
);
  import ihex_pkg::*;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
    if (out_free && load) begin
      out_res <= res;
    end
  end

endmodule
